FILE: src/w6ps_pkg.sv
// Shared types, constants and command/status records of the wheel-6 prime sieve.
package w6ps_pkg;

  localparam int unsigned MAX_BYTES_DEF = 1024;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned NUM_W     = 16;
  localparam int unsigned LIM_W     = 16;
  localparam int unsigned P_W       = 9;
  localparam int unsigned PQ_W      = 6;
  localparam int unsigned PQ2_W     = 12;
  localparam int unsigned PSQ_W     = 18;
  localparam int unsigned M_W       = 17;
  localparam int unsigned MQ_W      = 14;
  localparam int unsigned RES_W     = 3;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned DIV6_SHIFT = 18;

  localparam logic [CFG_W-1:0] CFG_RESET   = 11'd16;
  localparam logic [NUM_W-1:0] DIV6_RECIP  = 16'd43691;
  localparam logic [5:0]       BYTE_SPAN   = 6'd48;
  localparam logic [2:0]       WHEEL       = 3'd6;
  localparam logic [P_W-1:0]   P_FIRST     = 9'd5;
  localparam logic [RES_W-1:0] RES_ONE     = 3'd1;
  localparam logic [RES_W-1:0] RES_FIVE    = 3'd5;
  localparam logic [NUM_W-1:0] NUM_TWO     = 16'd2;
  localparam logic [NUM_W-1:0] NUM_THREE   = 16'd3;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [NUM_W-1:0] query_number;
  } req_t;

  typedef struct packed {
    logic prime_flag;
    logic out_of_range;
    logic build_done;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic build_start;
    logic clear_wr;
    logic p_init;
    logic p_rd;
    logic p_next;
    logic m_init;
    logic m_mark;
    logic q_rd;
    logic load_out;
    logic out_build;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic p_over;
    logic p_prime;
    logic m_over;
  } sts_t;

endpackage

FILE: src/w6ps_stream_if.sv
// Valid/ready stream interface carrying one payload record per request.
interface w6ps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/w6ps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module w6ps_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/w6ps_dp.sv
// Sieve datapath: configuration, limit, candidate and multiple counters, maps and result.
module w6ps_dp #(
  parameter int unsigned MAX_BYTES = w6ps_pkg::MAX_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [w6ps_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  w6ps_pkg::req_t                req_i,
  input  w6ps_pkg::cmd_t                cmd_i,
  output w6ps_pkg::sts_t                sts_o,
  output w6ps_pkg::rsp_t                rsp_o
);

  localparam int unsigned DEPTH = MAX_BYTES * 8;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  logic [w6ps_pkg::CFG_W-1:0]  sieve_bytes_q;
  logic                        built_q;
  logic [w6ps_pkg::LIM_W-1:0]  limit_q;
  logic [CNT_W-1:0]            clr_idx_q, clr_n_q;

  logic [w6ps_pkg::P_W-1:0]    p_q;
  logic [w6ps_pkg::PQ_W-1:0]   pq_q;
  logic                        p_is5_q;
  logic [w6ps_pkg::PSQ_W-1:0]  psq_q;
  logic [w6ps_pkg::PQ2_W-1:0]  pq2_q;

  logic [w6ps_pkg::M_W-1:0]    m_q;
  logic [w6ps_pkg::MQ_W-1:0]   mq_q;
  logic [w6ps_pkg::RES_W-1:0]  mr_q;

  logic [w6ps_pkg::NUM_W-1:0]  num_q;
  logic [w6ps_pkg::MQ_W-1:0]   quo_q;
  logic [w6ps_pkg::RES_W-1:0]  res_q;
  w6ps_pkg::rsp_t              rsp_q;

  logic [w6ps_pkg::CFG_W-1:0]  bytes_sat;
  logic [w6ps_pkg::M_W-1:0]    lim_full;
  logic [w6ps_pkg::PROD_W-1:0] div_prod;
  logic [w6ps_pkg::M_W-1:0]    quo_times6;
  logic [w6ps_pkg::MQ_W-1:0]   mq_init;
  logic [w6ps_pkg::RES_W:0]    mr_sum;

  logic             we_one, we_five, ram_re, wdata;
  logic [IDX_W-1:0] waddr, raddr;
  logic             rd_one, rd_five;
  logic             q_oor, q_prime;

  // Saturate the byte count and scale it to the covered limit.
  always_comb begin
    bytes_sat = sieve_bytes_q;
    if (sieve_bytes_q > w6ps_pkg::CFG_W'(MAX_BYTES)) begin
      bytes_sat = w6ps_pkg::CFG_W'(MAX_BYTES);
    end
    lim_full = w6ps_pkg::M_W'(bytes_sat) * w6ps_pkg::M_W'(w6ps_pkg::BYTE_SPAN);
  end

  // Division by six through a reciprocal multiply; exact for 16-bit operands.
  assign div_prod   = w6ps_pkg::PROD_W'(num_q) * w6ps_pkg::PROD_W'(w6ps_pkg::DIV6_RECIP);
  assign quo_times6 = w6ps_pkg::M_W'(quo_q) * w6ps_pkg::M_W'(w6ps_pkg::WHEEL);

  // Index of p squared: residue is always one, quotient follows from p = 6q + 1 or 6q + 5.
  always_comb begin
    if (p_is5_q) begin
      mq_init = w6ps_pkg::MQ_W'(pq2_q) * w6ps_pkg::MQ_W'(w6ps_pkg::WHEEL)
              + w6ps_pkg::MQ_W'(pq_q) * w6ps_pkg::MQ_W'(10) + w6ps_pkg::MQ_W'(4);
    end else begin
      mq_init = w6ps_pkg::MQ_W'(pq2_q) * w6ps_pkg::MQ_W'(w6ps_pkg::WHEEL)
              + w6ps_pkg::MQ_W'({pq_q, 1'b0});
    end
  end

  assign mr_sum = {1'b0, mr_q} + (p_is5_q ? {1'b0, w6ps_pkg::RES_FIVE}
                                          : {1'b0, w6ps_pkg::RES_ONE});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_bytes_q <= w6ps_pkg::CFG_RESET;
      built_q       <= 1'b0;
      limit_q       <= '0;
      clr_idx_q     <= '0;
      clr_n_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        sieve_bytes_q <= cfg_wdata_i;
      end
      if (cmd_i.build_start) begin
        built_q   <= 1'b1;
        limit_q   <= w6ps_pkg::LIM_W'(lim_full);
        clr_idx_q <= '0;
        clr_n_q   <= CNT_W'({bytes_sat, 3'b000});
      end else if (cmd_i.clear_wr) begin
        clr_idx_q <= clr_idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    psq_q <= w6ps_pkg::PSQ_W'(p_q) * w6ps_pkg::PSQ_W'(p_q);
    pq2_q <= w6ps_pkg::PQ2_W'(pq_q) * w6ps_pkg::PQ2_W'(pq_q);
    quo_q <= div_prod[w6ps_pkg::DIV6_SHIFT +: w6ps_pkg::MQ_W];
    res_q <= w6ps_pkg::RES_W'(w6ps_pkg::M_W'(num_q) - quo_times6);

    if (cmd_i.accept) begin
      num_q <= req_i.query_number;
    end

    if (cmd_i.p_init) begin
      p_q     <= w6ps_pkg::P_FIRST;
      pq_q    <= '0;
      p_is5_q <= 1'b1;
    end else if (cmd_i.p_next) begin
      if (p_is5_q) begin
        p_q     <= p_q + w6ps_pkg::P_W'(2);
        pq_q    <= pq_q + w6ps_pkg::PQ_W'(1);
        p_is5_q <= 1'b0;
      end else begin
        p_q     <= p_q + w6ps_pkg::P_W'(4);
        p_is5_q <= 1'b1;
      end
    end

    if (cmd_i.m_init) begin
      m_q  <= w6ps_pkg::M_W'(psq_q);
      mq_q <= mq_init;
      mr_q <= w6ps_pkg::RES_ONE;
    end else if (cmd_i.m_mark) begin
      m_q <= m_q + w6ps_pkg::M_W'(p_q);
      if (mr_sum >= {1'b0, w6ps_pkg::WHEEL}) begin
        mr_q <= w6ps_pkg::RES_W'(mr_sum - {1'b0, w6ps_pkg::WHEEL});
        mq_q <= mq_q + w6ps_pkg::MQ_W'(pq_q) + w6ps_pkg::MQ_W'(1);
      end else begin
        mr_q <= w6ps_pkg::RES_W'(mr_sum);
        mq_q <= mq_q + w6ps_pkg::MQ_W'(pq_q);
      end
    end

    if (cmd_i.load_out) begin
      rsp_q.build_done   <= cmd_i.out_build;
      rsp_q.prime_flag   <= cmd_i.out_build ? 1'b0 : q_prime;
      rsp_q.out_of_range <= cmd_i.out_build ? 1'b0 : q_oor;
    end
  end

  // One port pair serves clearing, marking, candidate tests and queries.
  assign we_one  = cmd_i.clear_wr || (cmd_i.m_mark && mr_q == w6ps_pkg::RES_ONE);
  assign we_five = cmd_i.clear_wr || (cmd_i.m_mark && mr_q == w6ps_pkg::RES_FIVE);
  assign waddr   = cmd_i.clear_wr ? clr_idx_q[IDX_W-1:0] : IDX_W'(mq_q);
  assign wdata   = !cmd_i.clear_wr;
  assign ram_re  = cmd_i.p_rd || cmd_i.q_rd;
  assign raddr   = cmd_i.p_rd ? IDX_W'(pq_q) : IDX_W'(quo_q);

  w6ps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map_one (
    .clk_i   (clk_i),
    .we_i    (we_one),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rd_one)
  );

  w6ps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map_five (
    .clk_i   (clk_i),
    .we_i    (we_five),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rd_five)
  );

  always_comb begin
    q_oor   = !built_q || (num_q >= limit_q);
    q_prime = 1'b0;
    if (!q_oor) begin
      if (num_q == w6ps_pkg::NUM_TWO || num_q == w6ps_pkg::NUM_THREE) begin
        q_prime = 1'b1;
      end else if (num_q >= w6ps_pkg::NUM_TWO) begin
        q_prime = (res_q == w6ps_pkg::RES_ONE && !rd_one)
               || (res_q == w6ps_pkg::RES_FIVE && !rd_five);
      end
    end
  end

  assign sts_o.clear_done = clr_idx_q >= clr_n_q;
  assign sts_o.p_over     = psq_q > w6ps_pkg::PSQ_W'(limit_q);
  assign sts_o.p_prime    = p_is5_q ? !rd_five : !rd_one;
  assign sts_o.m_over     = m_q >= w6ps_pkg::M_W'(limit_q);
  assign rsp_o            = rsp_q;

endmodule

FILE: src/w6ps_ctrl.sv
// Sieve controller: sequences clearing, candidate walk, marking and queries.
module w6ps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_opcode_i,
  output logic           req_ready_o,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  input  w6ps_pkg::sts_t sts_i,
  output w6ps_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_P_WAIT,
    ST_P_CHK,
    ST_P_RD,
    ST_MARK,
    ST_Q_DIV,
    ST_Q_RD,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_build_q, out_build_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_build_d = out_build_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          if (req_opcode_i == w6ps_pkg::OP_BUILD) begin
            cmd_o.build_start = 1'b1;
            out_build_d       = 1'b1;
            state_d           = ST_CLEAR;
          end else begin
            out_build_d = 1'b0;
            state_d     = ST_Q_DIV;
          end
        end
      end
      ST_CLEAR: begin
        if (sts_i.clear_done) begin
          cmd_o.p_init = 1'b1;
          state_d      = ST_P_WAIT;
        end else begin
          cmd_o.clear_wr = 1'b1;
        end
      end
      ST_P_WAIT: begin
        state_d = ST_P_CHK;
      end
      ST_P_CHK: begin
        if (sts_i.p_over) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.p_rd = 1'b1;
          state_d    = ST_P_RD;
        end
      end
      ST_P_RD: begin
        if (sts_i.p_prime) begin
          cmd_o.m_init = 1'b1;
          state_d      = ST_MARK;
        end else begin
          cmd_o.p_next = 1'b1;
          state_d      = ST_P_WAIT;
        end
      end
      ST_MARK: begin
        if (sts_i.m_over) begin
          cmd_o.p_next = 1'b1;
          state_d      = ST_P_WAIT;
        end else begin
          cmd_o.m_mark = 1'b1;
        end
      end
      ST_Q_DIV: begin
        state_d = ST_Q_RD;
      end
      ST_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.out_build = out_build_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_build_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_build_q <= out_build_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

FILE: src/wheel6_prime_sieve.sv
// Top level of the wheel-6 bit-packed prime sieve.
// The block takes requests on req_i: opcode 0 builds the sieve, opcode 1 asks
// whether query_number is prime. Every request gives exactly one response on
// rsp_o, carrying prime_flag, out_of_range and build_done. The sieve_bytes
// register is written through cfg_we_i and cfg_wdata_i; the user must write it
// only while the block is idle, and the block itself does not enforce this. A
// build covers numbers below 48 times that byte count, capped at MAX_BYTES. A
// query registers its number, then the quotient and residue of the
// divide-by-six multiply, then reads the maps and loads the output register;
// a new request is taken only once the last response is loaded. A build
// first clears 8 * bytes map bits, one per cycle, then walks candidates 5, 7,
// 11, 13 and onward and marks the multiples of each prime one per cycle. The
// maps are single-port-write bit memories.
// After reset the register holds 16 and no build has been done, so queries
// report out_of_range until the first build; the maps are not cleared by
// reset, since every build clears the part it covers. A response waits in
// the output register while the receiver stalls, and the next request is
// still accepted; its own response is held back until the first is taken.
module wheel6_prime_sieve #(
  parameter int unsigned MAX_BYTES = w6ps_pkg::MAX_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  w6ps_stream_if.sink                req_i,
  w6ps_stream_if.source              rsp_o,
  input  logic                       cfg_we_i,
  input  logic [w6ps_pkg::CFG_W-1:0] cfg_wdata_i
);

  w6ps_pkg::cmd_t cmd;
  w6ps_pkg::sts_t sts;
  w6ps_pkg::req_t req_pl;
  w6ps_pkg::rsp_t rsp_pl;

  assign req_pl        = req_i.payload;
  assign rsp_o.payload = rsp_pl;

  // Control: request acceptance, build and query sequencing, response valid.
  w6ps_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_pl.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Datapath: register, limit, counters, the two residue maps and the result.
  w6ps_dp #(.MAX_BYTES(MAX_BYTES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_pl),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_pl)
  );

endmodule

FILE: src/w6ps_chk.sv
// Port-level checker for the wheel-6 prime sieve, bound to the top level.
module w6ps_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic prime_flag_i,
  input logic out_of_range_i,
  input logic build_done_i
);

  // A held response keeps its contents until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(prime_flag_i)
      && $stable(out_of_range_i) && $stable(build_done_i))
    else $error("response changed while stalled");

  // Work on one request at a time: busy right after an accepted request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous one still in work");

  // A build response carries no query flags.
  a_build_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && build_done_i |-> !prime_flag_i && !out_of_range_i)
    else $error("build response with query flags");

  // A prime answer is never out of range.
  a_prime_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && prime_flag_i |-> !out_of_range_i)
    else $error("prime reported for out-of-range query");

endmodule

bind wheel6_prime_sieve w6ps_chk u_w6ps_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .prime_flag_i   (rsp_o.payload.prime_flag),
  .out_of_range_i (rsp_o.payload.out_of_range),
  .build_done_i   (rsp_o.payload.build_done)
);
